@@ hw/rtl/block_buffer_cache_lru_core_defines.svh @@
// Assertion macros for the buffer cache RTL.
`ifndef BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BBC_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("bbc assertion failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bbc assertion failed");

`endif

@@ hw/rtl/bbc_pkg.sv @@
// Shared types, constants and codes of the block buffer cache.
package bbc_pkg;

   localparam int BUFFER_COUNT = 16;
   localparam int IDX_W = $clog2(BUFFER_COUNT);
   localparam int CNT_W = $clog2(BUFFER_COUNT + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [7:0]       sbits_type;

   // Bit positions in the per-buffer status byte.
   localparam int B_ASSOC   = 0;
   localparam int B_BUSY    = 1;
   localparam int B_WAITING = 2;
   localparam int B_DONE    = 3;
   localparam int B_DELAYED = 4;
   localparam int B_ASYNC   = 5;
   localparam int B_AGE     = 6;
   localparam int B_ERROR   = 7;

   // Request kinds.
   localparam logic [2:0] MODE_GET         = 3'd0;
   localparam logic [2:0] MODE_LOOKUP      = 3'd1;
   localparam logic [2:0] MODE_RELEASE     = 3'd2;
   localparam logic [2:0] MODE_START_WRITE = 3'd3;
   localparam logic [2:0] MODE_IO_DONE     = 3'd4;
   localparam logic [2:0] MODE_CANCEL      = 3'd5;

   // Result status codes.
   localparam logic [3:0] STS_GRANT_VALID = 4'd0;
   localparam logic [3:0] STS_GRANT_READ  = 4'd1;
   localparam logic [3:0] STS_BUSY_RETRY  = 4'd2;
   localparam logic [3:0] STS_NONE_FREE   = 4'd3;
   localparam logic [3:0] STS_WRITEBACK   = 4'd4;
   localparam logic [3:0] STS_FOUND       = 4'd5;
   localparam logic [3:0] STS_NOT_FOUND   = 4'd6;
   localparam logic [3:0] STS_RELEASED    = 4'd7;
   localparam logic [3:0] STS_WRITE_START = 4'd8;
   localparam logic [3:0] STS_WAITER_WOKE = 4'd9;
   localparam logic [3:0] STS_DONE_REL    = 4'd10;
   localparam logic [3:0] STS_ACK         = 4'd11;

   // Command to the tag memory: one address, read or write.
   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      idx_type     addr;
      logic [15:0] device;
      logic [15:0] block;
   } tag_cmd_type;

endpackage

@@ hw/rtl/bbc_channels.sv @@
// Request and result channel interfaces of the block buffer cache.
interface bbc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [3:0]  buffer_index;
   logic [15:0] device;
   logic        no_device;
   logic [15:0] block_number;
   logic        mark_delayed;
   logic        asynchronous;
   logic        io_error;

   modport source (output valid, mode, buffer_index, device, no_device, block_number,
                   mark_delayed, asynchronous, io_error, input ready);
   modport sink (input valid, mode, buffer_index, device, no_device, block_number,
                 mark_delayed, asynchronous, io_error, output ready);
endinterface

interface bbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [3:0]  result_index;
   logic [15:0] old_device;
   logic [15:0] old_block;
   logic        wake_buffer;
   logic        wake_free;

   modport source (output valid, status, result_index, old_device, old_block, wake_buffer,
                   wake_free, input ready);
   modport sink (input valid, status, result_index, old_device, old_block, wake_buffer,
                 wake_free, output ready);
endinterface

@@ hw/rtl/bbc_tag_ram.sv @@
// Tag memory of the buffer pool: device and block number per buffer.
module bbc_tag_ram (
   input  logic                 clock,
   input  bbc_pkg::tag_cmd_type cmd,
   output logic [15:0]          rd_device,
   output logic [15:0]          rd_block
);

   logic [31:0] mem [bbc_pkg::BUFFER_COUNT];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= {cmd.device, cmd.block};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_device = rd_data_ff[31:16];
   assign rd_block  = rd_data_ff[15:0];

endmodule

@@ hw/rtl/block_buffer_cache_lru_core.sv @@
// Top level of the block buffer cache: request control, free list and status store.
// The block manages tags and LRU replacement for a pool of BUFFER_COUNT block buffers. It works on
// one request at a time. Requests that search by tag (get, lookup, cancel with a device and a
// nonzero block) sweep the tag memory one entry per cycle through its single read port before the
// execute step, and a get that starts the writeback of a delayed-write buffer adds a writeback step,
// which reads that buffer's old tag. Release, start write, io done and searchless requests go
// straight to the execute step. The request side opens again in the cycle after the result is
// registered. A finished result sits in an output register, so the next request may be
// transferred while the previous result still waits to be taken; that request then holds in its
// last step until the result is taken. After reset every buffer is free and unassociated, and the
// free list holds the buffers in index order.
`include "block_buffer_cache_lru_core_defines.svh"

module block_buffer_cache_lru_core (
   input  logic   clock,
   input  logic   reset,
   bbc_req_if.sink   req_ch,
   bbc_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_WB
   } state_type;

   localparam int N = bbc_pkg::BUFFER_COUNT;

   state_type state_ff;

   // Registered request.
   logic [2:0]  mode_ff;
   logic [3:0]  bi_ff;
   logic [15:0] dev_ff;
   logic        nodev_ff;
   logic [15:0] blk_ff;
   logic        delay_ff;
   logic        async_ff;
   logic        ioerr_ff;

   // Pool state. Status bytes and free list live in flip-flops, tags in the tag memory.
   bbc_pkg::sbits_type sbits_ff [N];
   bbc_pkg::sbits_type sbits_in [N];
   bbc_pkg::idx_type   order_ff [N];
   bbc_pkg::idx_type   order_in [N];
   bbc_pkg::cnt_type   free_count_ff;
   bbc_pkg::cnt_type   free_count_in;
   logic               free_wanted_ff;
   logic               free_wanted_in;

   // Tag sweep.
   bbc_pkg::cnt_type   scan_cnt_ff;
   logic               chk_vld_ff;
   bbc_pkg::idx_type   chk_idx_ff;
   logic               hit_ff;
   bbc_pkg::idx_type   hit_idx_ff;
   logic               match;

   // Tag memory port.
   bbc_pkg::tag_cmd_type tag_cmd;
   logic [15:0]          rd_device;
   logic [15:0]          rd_block;

   // Output register.
   logic        rsp_valid_ff;
   logic [3:0]  rsp_status_ff;
   logic [3:0]  rsp_index_ff;
   logic [15:0] rsp_old_dev_ff;
   logic [15:0] rsp_old_blk_ff;
   logic        rsp_wb_ff;
   logic        rsp_wf_ff;

   // Execute-step results.
   logic               out_free;
   logic               commit;
   logic               need_wb;
   logic               tag_wr;
   logic [3:0]         o_status;
   logic [3:0]         o_index;
   logic               o_wake_buf;
   logic               o_wake_free;
   logic               bi_ok;
   bbc_pkg::idx_type   bi_idx;
   bbc_pkg::sbits_type s;

   // Free list edit: remove a target if present, then optionally insert it.
   bbc_pkg::idx_type   lst_tgt;
   logic               lst_rm;
   logic               lst_ins;
   logic               lst_head;
   bbc_pkg::idx_type   rem_list [N];
   bbc_pkg::cnt_type   rem_count;
   logic               seen;

   // Oldest free buffer without a pending delayed write, else the oldest free buffer.
   bbc_pkg::idx_type   pick;
   logic               pick_found;

   logic [N-1:0]       busy_vec;

   bbc_pkg::tag_cmd_type unused_cmd;

   bbc_tag_ram u_tag_ram (
      .clock     (clock),
      .cmd       (tag_cmd),
      .rd_device (rd_device),
      .rd_block  (rd_block)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // A swept entry matches when it is associated and its tag equals the request's tag.
   assign match = chk_vld_ff && !hit_ff && sbits_ff[chk_idx_ff][bbc_pkg::B_ASSOC] &&
                  (rd_device == dev_ff) && (rd_block == blk_ff);

   always_comb begin
      pick       = order_ff[0];
      pick_found = 1'b0;
      for (int p = 0; p < N; p++) begin
         if (!pick_found && (bbc_pkg::CNT_W'(p) < free_count_ff) &&
             !sbits_ff[order_ff[p]][bbc_pkg::B_DELAYED]) begin
            pick       = order_ff[p];
            pick_found = 1'b1;
         end
      end
   end

   // Main execute step: status bytes, free-list edit and the result of the request.
   always_comb begin
      sbits_in       = sbits_ff;
      free_wanted_in = free_wanted_ff;
      lst_tgt        = '0;
      lst_rm         = 1'b0;
      lst_ins        = 1'b0;
      lst_head       = 1'b0;
      need_wb        = 1'b0;
      tag_wr         = 1'b0;
      o_status       = bbc_pkg::STS_ACK;
      o_index        = '0;
      o_wake_buf     = 1'b0;
      o_wake_free    = 1'b0;
      bi_ok          = (int'(bi_ff) < N);
      bi_idx         = bbc_pkg::IDX_W'(bi_ff);
      s              = '0;

      case (mode_ff)
         bbc_pkg::MODE_GET: begin
            if (hit_ff) begin
               o_index = 4'(hit_idx_ff);
               if (sbits_ff[hit_idx_ff][bbc_pkg::B_BUSY]) begin
                  sbits_in[hit_idx_ff][bbc_pkg::B_WAITING] = 1'b1;
                  o_status = bbc_pkg::STS_BUSY_RETRY;
               end else begin
                  lst_tgt = hit_idx_ff;
                  lst_rm  = 1'b1;
                  sbits_in[hit_idx_ff][bbc_pkg::B_BUSY] = 1'b1;
                  o_status = sbits_ff[hit_idx_ff][bbc_pkg::B_DONE] ?
                             bbc_pkg::STS_GRANT_VALID : bbc_pkg::STS_GRANT_READ;
               end
            end else if (free_count_ff == '0) begin
               free_wanted_in = 1'b1;
               o_status       = bbc_pkg::STS_NONE_FREE;
            end else begin
               lst_tgt = pick;
               lst_rm  = 1'b1;
               o_index = 4'(pick);
               s       = sbits_ff[pick];
               if (s[bbc_pkg::B_DELAYED]) begin
                  s[bbc_pkg::B_DONE]    = 1'b0;
                  s[bbc_pkg::B_ERROR]   = 1'b0;
                  s[bbc_pkg::B_DELAYED] = 1'b0;
                  s[bbc_pkg::B_BUSY]    = 1'b1;
                  s[bbc_pkg::B_ASYNC]   = 1'b1;
                  s[bbc_pkg::B_AGE]     = 1'b1;
                  need_wb  = 1'b1;
                  o_status = bbc_pkg::STS_WRITEBACK;
               end else begin
                  s = '0;
                  s[bbc_pkg::B_BUSY]  = 1'b1;
                  s[bbc_pkg::B_ASSOC] = !nodev_ff;
                  tag_wr   = 1'b1;
                  o_status = bbc_pkg::STS_GRANT_READ;
               end
               sbits_in[pick] = s;
            end
         end
         bbc_pkg::MODE_LOOKUP: begin
            if (hit_ff) begin
               o_index  = 4'(hit_idx_ff);
               o_status = bbc_pkg::STS_FOUND;
            end else begin
               o_status = bbc_pkg::STS_NOT_FOUND;
            end
         end
         bbc_pkg::MODE_RELEASE, bbc_pkg::MODE_IO_DONE: begin
            if (bi_ok) begin
               o_index = bi_ff;
               s       = sbits_ff[bi_idx];
               if (mode_ff == bbc_pkg::MODE_RELEASE) begin
                  if (delay_ff) begin
                     s[bbc_pkg::B_DELAYED] = 1'b1;
                     s[bbc_pkg::B_DONE]    = 1'b1;
                  end
               end else begin
                  s[bbc_pkg::B_DONE] = 1'b1;
                  if (ioerr_ff) begin
                     s[bbc_pkg::B_ERROR] = 1'b1;
                  end
               end
               if (mode_ff == bbc_pkg::MODE_IO_DONE && !s[bbc_pkg::B_ASYNC]) begin
                  // Synchronous completion: wake the waiter, the caller releases later.
                  s[bbc_pkg::B_WAITING] = 1'b0;
                  o_wake_buf = 1'b1;
                  o_status   = bbc_pkg::STS_WAITER_WOKE;
               end else begin
                  o_wake_buf     = s[bbc_pkg::B_WAITING];
                  o_wake_free    = free_wanted_ff;
                  free_wanted_in = 1'b0;
                  if (s[bbc_pkg::B_ERROR]) begin
                     s[bbc_pkg::B_ASSOC] = 1'b0;
                  end
                  lst_tgt  = bi_idx;
                  lst_rm   = 1'b1;
                  lst_ins  = 1'b1;
                  lst_head = s[bbc_pkg::B_AGE];
                  s[bbc_pkg::B_WAITING] = 1'b0;
                  s[bbc_pkg::B_BUSY]    = 1'b0;
                  s[bbc_pkg::B_ASYNC]   = 1'b0;
                  s[bbc_pkg::B_AGE]     = 1'b0;
                  o_status = (mode_ff == bbc_pkg::MODE_RELEASE) ?
                             bbc_pkg::STS_RELEASED : bbc_pkg::STS_DONE_REL;
               end
               sbits_in[bi_idx] = s;
            end
         end
         bbc_pkg::MODE_START_WRITE: begin
            if (bi_ok) begin
               o_index = bi_ff;
               s       = sbits_ff[bi_idx];
               lst_tgt = bi_idx;
               lst_rm  = !s[bbc_pkg::B_BUSY];
               s[bbc_pkg::B_DONE]    = 1'b0;
               s[bbc_pkg::B_ERROR]   = 1'b0;
               s[bbc_pkg::B_DELAYED] = 1'b0;
               s[bbc_pkg::B_AGE]     = 1'b0;
               s[bbc_pkg::B_BUSY]    = 1'b1;
               if (async_ff || sbits_ff[bi_idx][bbc_pkg::B_ASYNC]) begin
                  s[bbc_pkg::B_ASYNC] = 1'b1;
                  s[bbc_pkg::B_AGE]   = sbits_ff[bi_idx][bbc_pkg::B_DELAYED];
               end
               sbits_in[bi_idx] = s;
               o_status = bbc_pkg::STS_WRITE_START;
            end
         end
         bbc_pkg::MODE_CANCEL: begin
            if (hit_ff) begin
               o_index = 4'(hit_idx_ff);
               sbits_in[hit_idx_ff][bbc_pkg::B_DELAYED] = 1'b0;
            end
         end
         default: begin
            o_status = bbc_pkg::STS_ACK;
         end
      endcase
   end

   // Free-list edit. A buffer appears at most once, so removal closes one gap.
   always_comb begin
      seen = 1'b0;
      for (int q = 0; q < N; q++) begin
         if (lst_rm && (bbc_pkg::CNT_W'(q) < free_count_ff) && (order_ff[q] == lst_tgt)) begin
            seen = 1'b1;
         end
         if (seen && (q + 1 < N)) begin
            rem_list[q] = order_ff[(q + 1) % N];
         end else begin
            rem_list[q] = order_ff[q];
         end
      end
      rem_count = free_count_ff - bbc_pkg::CNT_W'(seen);

      order_in      = rem_list;
      free_count_in = rem_count;
      if (lst_ins) begin
         if (lst_head) begin
            order_in[0] = lst_tgt;
            for (int q = 1; q < N; q++) begin
               order_in[q] = rem_list[q - 1];
            end
         end else begin
            order_in[rem_count[bbc_pkg::IDX_W-1:0]] = lst_tgt;
         end
         free_count_in = rem_count + 1'b1;
      end
   end

   assign commit = out_free && (((state_ff == ST_EXEC) && !need_wb) || (state_ff == ST_WB));

   // Tag memory: sweep reads, writeback tag read, tag write on a fresh grant.
   always_comb begin
      unused_cmd        = '0;
      tag_cmd           = unused_cmd;
      tag_cmd.device    = dev_ff;
      tag_cmd.block     = blk_ff;
      if (state_ff == ST_SCAN) begin
         tag_cmd.rd_en = (scan_cnt_ff < bbc_pkg::CNT_W'(N));
         tag_cmd.addr  = scan_cnt_ff[bbc_pkg::IDX_W-1:0];
      end else if (state_ff == ST_EXEC && need_wb) begin
         tag_cmd.rd_en = 1'b1;
         tag_cmd.addr  = pick;
      end else begin
         tag_cmd.wr_en = commit && tag_wr;
         tag_cmd.addr  = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_count_ff  <= bbc_pkg::CNT_W'(N);
         free_wanted_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hit_ff         <= 1'b0;
         chk_vld_ff     <= 1'b0;
         scan_cnt_ff    <= '0;
         for (int i = 0; i < N; i++) begin
            sbits_ff[i] <= '0;
            order_ff[i] <= bbc_pkg::IDX_W'(i);
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  mode_ff     <= req_ch.mode;
                  bi_ff       <= req_ch.buffer_index;
                  dev_ff      <= req_ch.device;
                  nodev_ff    <= req_ch.no_device;
                  blk_ff      <= req_ch.block_number;
                  delay_ff    <= req_ch.mark_delayed;
                  async_ff    <= req_ch.asynchronous;
                  ioerr_ff    <= req_ch.io_error;
                  hit_ff      <= 1'b0;
                  chk_vld_ff  <= 1'b0;
                  scan_cnt_ff <= '0;
                  if (!req_ch.no_device &&
                      ((req_ch.mode == bbc_pkg::MODE_GET) ||
                       (req_ch.mode == bbc_pkg::MODE_LOOKUP) ||
                       ((req_ch.mode == bbc_pkg::MODE_CANCEL) && (req_ch.block_number != '0))))
                  begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_EXEC;
                  end
               end
            end
            ST_SCAN: begin
               // Lowest matching index wins; the data of an address returns in the cycle after its read.
               chk_vld_ff <= tag_cmd.rd_en;
               chk_idx_ff <= tag_cmd.addr;
               if (tag_cmd.rd_en) begin
                  scan_cnt_ff <= scan_cnt_ff + 1'b1;
               end
               if (match) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= chk_idx_ff;
               end
               if (!tag_cmd.rd_en && !chk_vld_ff) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (need_wb) begin
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (commit) begin
            sbits_ff       <= sbits_in;
            order_ff       <= order_in;
            free_count_ff  <= free_count_in;
            free_wanted_ff <= free_wanted_in;
            rsp_valid_ff   <= 1'b1;
            rsp_status_ff  <= o_status;
            rsp_index_ff   <= o_index;
            rsp_old_dev_ff <= (state_ff == ST_WB) ? rd_device : 16'd0;
            rsp_old_blk_ff <= (state_ff == ST_WB) ? rd_block : 16'd0;
            rsp_wb_ff      <= o_wake_buf;
            rsp_wf_ff      <= o_wake_free;
            state_ff       <= ST_IDLE;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_index = rsp_index_ff;
   assign rsp_ch.old_device   = rsp_old_dev_ff;
   assign rsp_ch.old_block    = rsp_old_blk_ff;
   assign rsp_ch.wake_buffer  = rsp_wb_ff;
   assign rsp_ch.wake_free    = rsp_wf_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         busy_vec[i] = sbits_ff[i][bbc_pkg::B_BUSY];
      end
   end

   // A buffer is on the free list exactly when it is not busy.
   `BBC_ASSERT_ALWAYS(a_free_count_matches_busy, int'(free_count_ff) + $countones(busy_vec) == N)
   // Only one request is in work at a time.
   `BBC_ASSERT_NEXT(a_one_request_in_work, req_ch.valid && req_ch.ready, !req_ch.ready)
   // A tag hit always refers to an associated buffer while the request is in work.
   `BBC_ASSERT_ALWAYS(a_hit_is_associated, (state_ff == ST_IDLE) || !hit_ff || sbits_ff[hit_idx_ff][bbc_pkg::B_ASSOC])

endmodule
